/* hw/rtl/avnt_pkg.sv */
// shared types, constants and helpers for the affine vertex and normal transform
`timescale 1ns / 1ps

package avnt_pkg;

  // fraction bits of the matrix coefficients
  localparam int COEF_FRAC = 12;

  // integer square root: 32 root steps, two per stage
  localparam int SQ_STEPS = 32;
  localparam int SQ_PER   = 2;
  localparam int SQ_STG   = SQ_STEPS / SQ_PER;

  // unit component divide: 15 quotient bits, three per stage
  localparam int DV_STEPS = 15;
  localparam int DV_PER   = 3;
  localparam int DV_STG   = DV_STEPS / DV_PER;

  typedef logic [7:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ROW0    = 8'd0;
  localparam cfg_idx_t CFG_ROW1    = 8'd1;
  localparam cfg_idx_t CFG_ROW2    = 8'd2;
  localparam cfg_idx_t CFG_SHIFT_X = 8'd3;
  localparam cfg_idx_t CFG_SHIFT_Y = 8'd4;
  localparam cfg_idx_t CFG_SHIFT_Z = 8'd5;
  localparam cfg_idx_t CFG_SCALE   = 8'd6;
  localparam cfg_idx_t CFG_MAT_EN  = 8'd7;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] dir_t;

  // per word side band that rides along the whole pipe
  typedef struct packed {
    logic             kind;
    logic [2:0][15:0] dir;
    logic [2:0][31:0] nv;
    logic             vflag;
    logic             pass;
    logic [2:0]       neg;
  } carry_t;

  function automatic int nx3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int pv3(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

/* hw/rtl/affine_vertex_normal_transform.sv */
// affine vertex and cofactor normal transform, fully pipelined
// throughput: one word per cycle when the output is not stalled; the pipe depth
//   is set by the 16 root stages and 5 divide stages of the normal path,
//   vertices ride along the same stages
// a stall on the output holds every stage in place
// reset: synchronous, clears valids and loads identity matrix, unit scales, matrix off
`timescale 1ns / 1ps

module affine_vertex_normal_transform (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [143:0]         in_tdata,   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
  input  logic                 in_tuser,   // opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [143:0]         out_tdata,  // new_x, new_y, new_z, unit_x, unit_y, unit_z
  output logic [1:0]           out_tuser,  // kind, fell_back
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  avnt_pkg::cfg_idx_t   cfg_index,
  input  logic [63:0]          cfg_data
);
  import avnt_pkg::*;

  localparam int ST_SQ0 = 9;
  localparam int ST_J   = ST_SQ0 + SQ_STG;
  localparam int ST_DV0 = ST_J + 1;
  localparam int NSTG   = ST_DV0 + DV_STG;

  // configuration registers
  logic [47:0] row_r [3];
  coord_t      shift_r [3];
  logic [63:0] scale_r;
  logic        men_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= 48'h0000_0000_1000;
      row_r[1]   <= 48'h0000_1000_0000;
      row_r[2]   <= 48'h1000_0000_0000;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
      scale_r    <= 64'h0001_0000_0001_0000;
      men_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW0:    row_r[0]   <= cfg_data[47:0];
        CFG_ROW1:    row_r[1]   <= cfg_data[47:0];
        CFG_ROW2:    row_r[2]   <= cfg_data[47:0];
        CFG_SHIFT_X: shift_r[0] <= cfg_data[31:0];
        CFG_SHIFT_Y: shift_r[1] <= cfg_data[31:0];
        CFG_SHIFT_Z: shift_r[2] <= cfg_data[31:0];
        CFG_SCALE:   scale_r    <= cfg_data;
        CFG_MAT_EN:  men_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] a [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a[r][c] = row_r[r][16*c +: 16];
      end
    end
  end

  logic signed [32:0] pre_s, post_s;
  assign pre_s  = {1'b0, scale_r[31:0]};
  assign post_s = {1'b0, scale_r[63:32]};

  // pipe control
  logic            adv;
  logic            out_valid_r;
  logic [NSTG-1:0] vld_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_tvalid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  carry_t cry_r [NSTG];
  carry_t cry_nxt [NSTG];

  // stage a: pre-scale products, cofactor product pairs
  coord_t             a_pos_r [3];
  logic signed [63:0] a_pre_r [3], a_pre_nxt [3];
  logic signed [31:0] a_cp_r [3][3][2], a_cp_nxt [3][3][2];
  logic signed [64:0] pp [3];
  coord_t             pos_in [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pos_in[c]    = in_tdata[32*c +: 32];
      pp[c]        = pos_in[c] * pre_s;
      a_pre_nxt[c] = pp[c][63:0];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a_cp_nxt[r][c][0] = a[nx3(r)][nx3(c)] * a[pv3(r)][pv3(c)];
        a_cp_nxt[r][c][1] = a[nx3(r)][pv3(c)] * a[pv3(r)][nx3(c)];
      end
    end
  end

  // stage b: pre-scale round and range check, cofactors
  coord_t             b_p1_r [3], b_p1_nxt [3];
  logic signed [32:0] b_cof_r [3][3], b_cof_nxt [3][3];
  logic signed [63:0] b_rs [3], b_sh [3];
  logic               b_flag;

  always_comb begin
    b_flag = 1'b0;
    for (int c = 0; c < 3; c++) begin
      b_rs[c] = a_pre_r[c] + 64'sd32768;
      b_sh[c] = b_rs[c] >>> 16;
      if (b_sh[c][63:31] == '0 || b_sh[c][63:31] == '1) begin
        b_p1_nxt[c] = b_sh[c][31:0];
      end else begin
        b_p1_nxt[c] = a_pos_r[c];
        b_flag      = 1'b1;
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        b_cof_nxt[r][c] = a_cp_r[r][c][0] - a_cp_r[r][c][1];
      end
    end
  end

  // stage c: affine, determinant and normal products
  coord_t             c_p1_r [3];
  logic signed [47:0] c_aff_r [3][3], c_aff_nxt [3][3];
  logic signed [48:0] c_dp_r [3], c_dp_nxt [3];
  logic signed [48:0] c_vp_r [3][3], c_vp_nxt [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        c_aff_nxt[r][c] = a[r][c] * b_p1_r[c];
        c_vp_nxt[r][c]  = b_cof_r[r][c] * $signed(cry_r[1].dir[c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      c_dp_nxt[c] = a[0][c] * b_cof_r[0][c];
    end
  end

  // stage d: affine sums and range check, determinant and normal sums
  coord_t             d_p2_r [3], d_p2_nxt [3];
  logic signed [50:0] d_det_r, d_det_nxt;
  logic signed [50:0] d_v_r [3], d_v_nxt [3];
  logic signed [51:0] d_acc [3], d_t [3], d_tx [3];
  logic               d_fit, d_flag;

  always_comb begin
    d_fit = 1'b1;
    for (int r = 0; r < 3; r++) begin
      d_tx[r]  = shift_r[r];
      d_acc[r] = c_aff_r[r][0] + c_aff_r[r][1] + c_aff_r[r][2]
               + (d_tx[r] <<< COEF_FRAC) + (52'sd1 <<< (COEF_FRAC - 1));
      d_t[r]   = d_acc[r] >>> COEF_FRAC;
      if (!(d_t[r][51:31] == '0 || d_t[r][51:31] == '1)) d_fit = 1'b0;
    end
    for (int r = 0; r < 3; r++) begin
      d_p2_nxt[r] = (men_r && d_fit) ? d_t[r][31:0] : c_p1_r[r];
      d_v_nxt[r]  = c_vp_r[r][0] + c_vp_r[r][1] + c_vp_r[r][2];
    end
    d_flag    = men_r && !d_fit;
    d_det_nxt = c_dp_r[0] + c_dp_r[1] + c_dp_r[2];
  end

  // stage e: post-scale products, signed normal magnitudes
  coord_t             e_p2_r [3];
  logic signed [63:0] e_post_r [3], e_post_nxt [3];
  logic [49:0]        e_mag_r [3], e_mag_nxt [3];
  logic signed [64:0] e_pp [3];
  logic signed [50:0] e_vs [3], e_abs [3];
  logic [2:0]         e_neg;
  logic               e_pass;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_pp[c]       = d_p2_r[c] * post_s;
      e_post_nxt[c] = e_pp[c][63:0];
      e_vs[c]       = d_det_r[50] ? -d_v_r[c] : d_v_r[c];
      e_neg[c]      = e_vs[c][50];
      e_abs[c]      = e_neg[c] ? -e_vs[c] : e_vs[c];
      e_mag_nxt[c]  = e_abs[c][49:0];
    end
    e_pass = !men_r || (d_det_r == '0);
  end

  // stage f: post-scale round, leading one of the normal
  logic [49:0]        f_mag_r [3];
  logic [5:0]         f_msb_r, f_msb_nxt;
  logic signed [63:0] f_rs [3], f_sh [3];
  logic [49:0]        f_or;
  logic               f_fit, f_zero;
  logic [2:0][31:0]   f_nv;

  always_comb begin
    f_fit = 1'b1;
    for (int c = 0; c < 3; c++) begin
      f_rs[c] = e_post_r[c] + 64'sd32768;
      f_sh[c] = f_rs[c] >>> 16;
      if (!(f_sh[c][63:31] == '0 || f_sh[c][63:31] == '1)) f_fit = 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      f_nv[c] = f_fit ? f_sh[c][31:0] : e_p2_r[c];
    end
    f_or      = e_mag_r[0] | e_mag_r[1] | e_mag_r[2];
    f_zero    = (f_or == '0);
    f_msb_nxt = '0;
    for (int i = 0; i < 50; i++) begin
      if (f_or[i]) f_msb_nxt = 6'(i);
    end
  end

  // stage g: bring the largest magnitude into [2^29, 2^30)
  logic [29:0] g_m_r [3], g_m_nxt [3];
  logic [49:0] g_sh [3];
  logic [5:0]  g_rsh, g_lsh;

  always_comb begin
    g_rsh = f_msb_r - 6'd29;
    g_lsh = 6'd29 - f_msb_r;
    for (int c = 0; c < 3; c++) begin
      g_sh[c]    = (f_msb_r >= 6'd29) ? (f_mag_r[c] >> g_rsh) : (f_mag_r[c] << g_lsh);
      g_m_nxt[c] = g_sh[c][29:0];
    end
  end

  // stage h: squares, stage i: length squared
  logic [29:0] h_m_r [3];
  logic [59:0] h_sq_r [3], h_sq_nxt [3];
  logic [29:0] i_m_r [3];
  logic [61:0] i_l2_r, i_l2_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      h_sq_nxt[c] = g_m_r[c] * g_m_r[c];
    end
    i_l2_nxt = h_sq_r[0] + h_sq_r[1] + h_sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pos_r  <= pos_in;
      a_pre_r  <= a_pre_nxt;
      a_cp_r   <= a_cp_nxt;
      b_p1_r   <= b_p1_nxt;
      b_cof_r  <= b_cof_nxt;
      c_p1_r   <= b_p1_r;
      c_aff_r  <= c_aff_nxt;
      c_dp_r   <= c_dp_nxt;
      c_vp_r   <= c_vp_nxt;
      d_p2_r   <= d_p2_nxt;
      d_det_r  <= d_det_nxt;
      d_v_r    <= d_v_nxt;
      e_p2_r   <= d_p2_r;
      e_post_r <= e_post_nxt;
      e_mag_r  <= e_mag_nxt;
      f_mag_r  <= e_mag_r;
      f_msb_r  <= f_msb_nxt;
      g_m_r    <= g_m_nxt;
      h_m_r    <= g_m_r;
      h_sq_r   <= h_sq_nxt;
      i_m_r    <= h_m_r;
      i_l2_r   <= i_l2_nxt;
    end
  end

  // integer square root, digit by digit
  logic [63:0] sq_x_in [SQ_STG], sq_r_in [SQ_STG];
  logic [29:0] sq_m_in [SQ_STG][3];
  logic [63:0] sq_x_r [SQ_STG], sq_x_nxt [SQ_STG];
  logic [63:0] sq_r_r [SQ_STG], sq_r_nxt [SQ_STG];
  logic [29:0] sq_m_r [SQ_STG][3];

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
    if (k == 0) begin : g_first
      assign sq_x_in[k] = {2'b00, i_l2_r};
      assign sq_r_in[k] = '0;
      assign sq_m_in[k] = i_m_r;
    end else begin : g_rest
      assign sq_x_in[k] = sq_x_r[k-1];
      assign sq_r_in[k] = sq_r_r[k-1];
      assign sq_m_in[k] = sq_m_r[k-1];
    end

    always_comb begin
      logic [63:0] x, r, b;
      x = sq_x_in[k];
      r = sq_r_in[k];
      for (int j = 0; j < SQ_PER; j++) begin
        b = 64'd1 << (62 - 2 * (k * SQ_PER + j));
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      sq_x_nxt[k] = x;
      sq_r_nxt[k] = r;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x_r[k] <= sq_x_nxt[k];
        sq_r_r[k] <= sq_r_nxt[k];
        sq_m_r[k] <= sq_m_in[k];
      end
    end
  end

  // stage j: set up the three divides by the root
  // dividend can pass 2^44 when the largest magnitude is near 2^30
  logic [30:0] j_q_r, j_q;
  logic [31:0] j_rem_r [3], j_rem_nxt [3];
  logic [14:0] j_low_r [3], j_low_nxt [3];
  logic [44:0] j_dd [3];

  always_comb begin
    j_q = sq_r_r[SQ_STG-1][30:0];
    for (int c = 0; c < 3; c++) begin
      j_dd[c]      = {1'b0, sq_m_r[SQ_STG-1][c], 14'd0} + {15'd0, j_q[30:1]};
      j_rem_nxt[c] = {2'd0, j_dd[c][44:15]};
      j_low_nxt[c] = j_dd[c][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_q_r   <= j_q;
      j_rem_r <= j_rem_nxt;
      j_low_r <= j_low_nxt;
    end
  end

  // restoring divide, quotient bits msb first
  logic [30:0] dv_q_in [DV_STG], dv_q_r [DV_STG];
  logic [31:0] dv_rem_in [DV_STG][3], dv_rem_r [DV_STG][3], dv_rem_nxt [DV_STG][3];
  logic [14:0] dv_low_in [DV_STG][3], dv_low_r [DV_STG][3];
  logic [14:0] dv_quo_in [DV_STG][3], dv_quo_r [DV_STG][3], dv_quo_nxt [DV_STG][3];

  for (genvar k = 0; k < DV_STG; k++) begin : g_dv
    if (k == 0) begin : g_first
      assign dv_q_in[k]   = j_q_r;
      assign dv_rem_in[k] = j_rem_r;
      assign dv_low_in[k] = j_low_r;
      assign dv_quo_in[k] = '{default: '0};
    end else begin : g_rest
      assign dv_q_in[k]   = dv_q_r[k-1];
      assign dv_rem_in[k] = dv_rem_r[k-1];
      assign dv_low_in[k] = dv_low_r[k-1];
      assign dv_quo_in[k] = dv_quo_r[k-1];
    end

    always_comb begin
      logic [31:0] rm;
      logic [14:0] qu;
      for (int c = 0; c < 3; c++) begin
        rm = dv_rem_in[k][c];
        qu = dv_quo_in[k][c];
        for (int j = 0; j < DV_PER; j++) begin
          rm = {rm[30:0], dv_low_in[k][c][DV_STEPS - 1 - (k * DV_PER + j)]};
          if (rm >= {1'b0, dv_q_in[k]}) begin
            rm = rm - {1'b0, dv_q_in[k]};
            qu[DV_STEPS - 1 - (k * DV_PER + j)] = 1'b1;
          end
        end
        dv_rem_nxt[k][c] = rm;
        dv_quo_nxt[k][c] = qu;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_q_r[k]   <= dv_q_in[k];
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_low_r[k] <= dv_low_in[k];
        dv_quo_r[k] <= dv_quo_nxt[k];
      end
    end
  end

  // side band: copied down the pipe, filled in where each path settles
  always_comb begin
    cry_nxt[0].kind  = in_tuser;
    for (int c = 0; c < 3; c++) begin
      cry_nxt[0].dir[c] = in_tdata[96 + 16*c +: 16];
    end
    cry_nxt[0].nv    = '0;
    cry_nxt[0].vflag = 1'b0;
    cry_nxt[0].pass  = 1'b0;
    cry_nxt[0].neg   = '0;
    for (int i = 1; i < NSTG; i++) begin
      cry_nxt[i] = cry_r[i-1];
    end
    cry_nxt[1].vflag = b_flag;
    cry_nxt[3].vflag = cry_r[2].vflag | d_flag;
    cry_nxt[4].pass  = e_pass;
    cry_nxt[4].neg   = e_neg;
    cry_nxt[5].nv    = f_nv;
    cry_nxt[5].vflag = cry_r[4].vflag | !f_fit;
    cry_nxt[5].pass  = cry_r[4].pass | f_zero;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cry_r <= cry_nxt;
    end
  end

  // output assembly and register
  carry_t             fin;
  logic [15:0]        fin_u [3];
  logic [31:0]        fin_new_nxt [3];
  logic [15:0]        fin_unit_nxt [3];
  logic               fin_fell_nxt;
  logic               kind_r, fell_r;
  logic [31:0]        new_r [3];
  logic [15:0]        unit_r [3];

  always_comb begin
    fin = cry_r[NSTG-1];
    for (int c = 0; c < 3; c++) begin
      fin_u[c] = {1'b0, dv_quo_r[DV_STG-1][c]};
      if (fin.kind) begin
        fin_new_nxt[c]  = '0;
        fin_unit_nxt[c] = fin.pass ? fin.dir[c] : (fin.neg[c] ? 16'(-fin_u[c]) : fin_u[c]);
      end else begin
        fin_new_nxt[c]  = fin.nv[c];
        fin_unit_nxt[c] = '0;
      end
    end
    fin_fell_nxt = fin.kind ? fin.pass : fin.vflag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= fin.kind;
      fell_r <= fin_fell_nxt;
      new_r  <= fin_new_nxt;
      unit_r <= fin_unit_nxt;
    end
  end

  assign out_tdata = {unit_r[2], unit_r[1], unit_r[0], new_r[2], new_r[1], new_r[0]};
  assign out_tuser = {fell_r, kind_r};

endmodule
